// ===== rtl/core/ccao_pkg.sv =====
package ccao_pkg;

  // Field widths and fixed-point format.
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_W      = 40;

  // Derived internal widths; each holds its value range exactly.
  localparam int D_W   = COORD_BITS + 1;          // coordinate differences
  localparam int SQ_W  = 2 * COORD_BITS;          // single squares
  localparam int DS_W  = 2 * COORD_BITS + 1;      // squared-radius differences
  localparam int PA_W  = 2 * D_W;                 // products of differences
  localparam int A_W   = PA_W + 1;                // orientation determinant
  localparam int P_W   = DS_W + D_W;              // numerator partial products
  localparam int N_W   = P_W + 1;                 // numerators
  localparam int ABS_W = 3 * COORD_BITS + 1;      // numerator magnitudes
  localparam int MAG_W = ABS_W + FRAC_BITS;       // scaled dividend, quotient width
  localparam int DIV_W = A_W;                     // divisor 2|a|
  localparam int QE_W  = ((MAG_W > OUT_W) ? MAG_W : OUT_W) + 1;

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // One slot of the divider pipeline: both lanes share the divisor.
  typedef struct packed {
    logic             valid;
    logic             neg_x;
    logic             neg_y;
    logic             is_cw;
    logic             degenerate;
    logic [DIV_W-1:0] d;
    logic [DIV_W-1:0] rem_x;
    logic [DIV_W-1:0] rem_y;
    logic [MAG_W-1:0] mq_x;
    logic [MAG_W-1:0] mq_y;
  } divq_t;

endpackage

// ===== rtl/core/ccao_front.sv =====
module ccao_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [ccao_pkg::COORD_BITS-1:0] first_x,
  input  logic signed [ccao_pkg::COORD_BITS-1:0] first_y,
  input  logic signed [ccao_pkg::COORD_BITS-1:0] second_x,
  input  logic signed [ccao_pkg::COORD_BITS-1:0] second_y,
  input  logic signed [ccao_pkg::COORD_BITS-1:0] third_x,
  input  logic signed [ccao_pkg::COORD_BITS-1:0] third_y,
  output ccao_pkg::divq_t                      out_st
);

  localparam int D_W   = ccao_pkg::D_W;
  localparam int SQ_W  = ccao_pkg::SQ_W;
  localparam int DS_W  = ccao_pkg::DS_W;
  localparam int PA_W  = ccao_pkg::PA_W;
  localparam int A_W   = ccao_pkg::A_W;
  localparam int P_W   = ccao_pkg::P_W;
  localparam int N_W   = ccao_pkg::N_W;
  localparam int ABS_W = ccao_pkg::ABS_W;
  localparam int MAG_W = ccao_pkg::MAG_W;
  localparam int DIV_W = ccao_pkg::DIV_W;

  // Stage 1 registers.
  logic                   v1;
  logic signed [D_W-1:0]  dx2_s1, dy2_s1, dx3_s1, dy3_s1;
  logic signed [SQ_W-1:0] sqx1, sqy1, sqx2, sqy2, sqx3, sqy3;

  // Stage 2 registers.
  logic                   v2;
  logic signed [D_W-1:0]  dx2_s2, dy2_s2, dx3_s2, dy3_s2;
  logic signed [DS_W-1:0] ds2, ds3;
  logic signed [PA_W-1:0] pa, pb;

  // Stage 3 registers.
  logic                   v3;
  logic signed [A_W-1:0]  a3;
  logic signed [P_W-1:0]  p1, p2, p3, p4;

  // Stage 4 combinational terms.
  logic signed [N_W-1:0]  ny, nx;
  logic [N_W-1:0]         ny_mag, nx_mag;
  logic [A_W-1:0]         a_mag;

  // Stage 1: differences against the first point and the six squares.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      dx2_s1 <= D_W'(second_x) - D_W'(first_x);
      dy2_s1 <= D_W'(second_y) - D_W'(first_y);
      dx3_s1 <= D_W'(third_x) - D_W'(first_x);
      dy3_s1 <= D_W'(third_y) - D_W'(first_y);
      sqx1   <= SQ_W'(first_x) * SQ_W'(first_x);
      sqy1   <= SQ_W'(first_y) * SQ_W'(first_y);
      sqx2   <= SQ_W'(second_x) * SQ_W'(second_x);
      sqy2   <= SQ_W'(second_y) * SQ_W'(second_y);
      sqx3   <= SQ_W'(third_x) * SQ_W'(third_x);
      sqy3   <= SQ_W'(third_y) * SQ_W'(third_y);
    end
  end

  // Stage 2: squared-radius differences and the orientation products.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      dx2_s2 <= dx2_s1;
      dy2_s2 <= dy2_s1;
      dx3_s2 <= dx3_s1;
      dy3_s2 <= dy3_s1;
      ds2    <= (DS_W'(sqx2) + DS_W'(sqy2)) - (DS_W'(sqx1) + DS_W'(sqy1));
      ds3    <= (DS_W'(sqx3) + DS_W'(sqy3)) - (DS_W'(sqx1) + DS_W'(sqy1));
      pa     <= PA_W'(dx2_s1) * PA_W'(dy3_s1);
      pb     <= PA_W'(dx3_s1) * PA_W'(dy2_s1);
    end
  end

  // Stage 3: orientation determinant and the four numerator products.
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      a3 <= A_W'(pa) - A_W'(pb);
      p1 <= P_W'(ds2) * P_W'(dy3_s2);
      p2 <= P_W'(ds3) * P_W'(dy2_s2);
      p3 <= P_W'(ds3) * P_W'(dx2_s2);
      p4 <= P_W'(ds2) * P_W'(dx3_s2);
    end
  end

  // Stage 4: numerators, their magnitudes and the divisor 2|a|.
  always_comb begin
    ny     = N_W'(p1) - N_W'(p2);
    nx     = N_W'(p3) - N_W'(p4);
    ny_mag = ny[N_W-1] ? N_W'(-ny) : N_W'(ny);
    nx_mag = nx[N_W-1] ? N_W'(-nx) : N_W'(nx);
    a_mag  = a3[A_W-1] ? A_W'(-a3) : A_W'(a3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_st.valid <= 1'b0;
    end else if (en) begin
      out_st.valid <= v3;
    end
    if (en) begin
      out_st.neg_x      <= ny[N_W-1] ^ a3[A_W-1];
      out_st.neg_y      <= nx[N_W-1] ^ a3[A_W-1];
      out_st.is_cw      <= ~a3[A_W-1] && (a3 != '0);
      out_st.degenerate <= (a3 == '0);
      out_st.d          <= DIV_W'({a_mag[A_W-2:0], 1'b0});
      out_st.rem_x      <= '0;
      out_st.rem_y      <= '0;
      out_st.mq_x       <= MAG_W'(ny_mag[ABS_W-1:0]) << ccao_pkg::FRAC_BITS;
      out_st.mq_y       <= MAG_W'(nx_mag[ABS_W-1:0]) << ccao_pkg::FRAC_BITS;
    end
  end

endmodule

// ===== rtl/core/ccao_div_stage.sv =====
module ccao_div_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  ccao_pkg::divq_t in_st,
  output ccao_pkg::divq_t out_st
);

  localparam int DIV_W = ccao_pkg::DIV_W;
  localparam int MAG_W = ccao_pkg::MAG_W;

  logic [DIV_W:0]   trial_x, trial_y;
  logic             ge_x, ge_y;
  logic [DIV_W-1:0] rem_x_next, rem_y_next;

  // One restoring step per lane: bring down the next dividend bit and
  // subtract the divisor when it fits.
  always_comb begin
    trial_x    = {in_st.rem_x, in_st.mq_x[MAG_W-1]};
    trial_y    = {in_st.rem_y, in_st.mq_y[MAG_W-1]};
    ge_x       = (trial_x >= {1'b0, in_st.d});
    ge_y       = (trial_y >= {1'b0, in_st.d});
    rem_x_next = ge_x ? DIV_W'(trial_x - {1'b0, in_st.d}) : trial_x[DIV_W-1:0];
    rem_y_next = ge_y ? DIV_W'(trial_y - {1'b0, in_st.d}) : trial_y[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_st.valid <= 1'b0;
    end else if (en) begin
      out_st.valid <= in_st.valid;
    end
    if (en) begin
      out_st.neg_x      <= in_st.neg_x;
      out_st.neg_y      <= in_st.neg_y;
      out_st.is_cw      <= in_st.is_cw;
      out_st.degenerate <= in_st.degenerate;
      out_st.d          <= in_st.d;
      out_st.rem_x      <= rem_x_next;
      out_st.rem_y      <= rem_y_next;
      out_st.mq_x       <= {in_st.mq_x[MAG_W-2:0], ge_x};
      out_st.mq_y       <= {in_st.mq_y[MAG_W-2:0], ge_y};
    end
  end

endmodule

// ===== rtl/core/ccao_back.sv =====
module ccao_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  ccao_pkg::divq_t                     in_st,
  output logic                                out_valid,
  output logic signed [ccao_pkg::OUT_W-1:0]   circle_x,
  output logic signed [ccao_pkg::OUT_W-1:0]   circle_y,
  output logic                                is_cw,
  output logic                                degenerate,
  output logic                                saturated
);

  localparam int OUT_W = ccao_pkg::OUT_W;
  localparam int QE_W  = ccao_pkg::QE_W;
  localparam logic [QE_W-1:0] LIM = QE_W'(1) << (OUT_W - 1);

  logic [QE_W-1:0]  qx, qy;
  logic             sat_x, sat_y;
  logic [OUT_W-1:0] val_x, val_y;

  // Apply the sign and clip to the output range.
  always_comb begin
    qx = QE_W'(in_st.mq_x);
    qy = QE_W'(in_st.mq_y);
    if (in_st.neg_x) begin
      sat_x = (qx > LIM);
      val_x = sat_x ? ccao_pkg::OUT_MIN : OUT_W'(QE_W'(0) - qx);
    end else begin
      sat_x = (qx > LIM - QE_W'(1));
      val_x = sat_x ? ccao_pkg::OUT_MAX : OUT_W'(qx);
    end
    if (in_st.neg_y) begin
      sat_y = (qy > LIM);
      val_y = sat_y ? ccao_pkg::OUT_MIN : OUT_W'(QE_W'(0) - qy);
    end else begin
      sat_y = (qy > LIM - QE_W'(1));
      val_y = sat_y ? ccao_pkg::OUT_MAX : OUT_W'(qy);
    end
  end

  // Output register; collinear points give a zero center.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_st.valid;
    end
    if (en) begin
      circle_x   <= in_st.degenerate ? '0 : val_x;
      circle_y   <= in_st.degenerate ? '0 : val_y;
      is_cw      <= in_st.is_cw;
      degenerate <= in_st.degenerate;
      saturated  <= ~in_st.degenerate & (sat_x | sat_y);
    end
  end

endmodule

// ===== rtl/core/circumcenter_and_orientation.sv =====
// Circumcenter and orientation of three arc points.
// Input channel: in_valid/in_ready carries one request of three points
// (first, second, third), each coordinate 16-bit two's complement.
// Output channel: out_valid/out_ready carries the center circle_x, circle_y
// in units of 1/256 (truncated toward zero, clipped to 40 bits), is_cw when
// the orientation determinant is positive, degenerate for collinear points
// (center then zero) and saturated when a coordinate was clipped.
// The pipeline has 4 + 57 + 1 = 62 register stages: four front stages form
// the determinants, the two restoring dividers take one quotient bit per
// stage over 57 stages, and one stage applies the sign and clips.
// Throughput is one request per cycle while no result waits on out_ready.
// The whole pipeline advances together; when the receiver holds out_ready
// low with a result waiting, every stage holds and in_ready drops, so no
// request is lost or repeated. Empty slots hold as well.
// Synchronous reset clears all valid bits; the pipeline starts empty.
module circumcenter_and_orientation (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [ccao_pkg::COORD_BITS-1:0] first_x,
  input  logic signed [ccao_pkg::COORD_BITS-1:0] first_y,
  input  logic signed [ccao_pkg::COORD_BITS-1:0] second_x,
  input  logic signed [ccao_pkg::COORD_BITS-1:0] second_y,
  input  logic signed [ccao_pkg::COORD_BITS-1:0] third_x,
  input  logic signed [ccao_pkg::COORD_BITS-1:0] third_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [ccao_pkg::OUT_W-1:0]     circle_x,
  output logic signed [ccao_pkg::OUT_W-1:0]     circle_y,
  output logic                                  is_cw,
  output logic                                  degenerate,
  output logic                                  saturated
);

  localparam int MAG_W = ccao_pkg::MAG_W;

  logic            en;
  ccao_pkg::divq_t chain [0:MAG_W];

  // Global advance: move whenever the output slot is empty or being taken.
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  ccao_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .first_x  (first_x),
    .first_y  (first_y),
    .second_x (second_x),
    .second_y (second_y),
    .third_x  (third_x),
    .third_y  (third_y),
    .out_st   (chain[0])
  );

  // Divider stages, one quotient bit each.
  for (genvar i = 0; i < MAG_W; i++) begin : g_div
    ccao_div_stage u_stage (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .in_st  (chain[i]),
      .out_st (chain[i+1])
    );
  end

  ccao_back u_back (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_st      (chain[MAG_W]),
    .out_valid  (out_valid),
    .circle_x   (circle_x),
    .circle_y   (circle_y),
    .is_cw      (is_cw),
    .degenerate (degenerate),
    .saturated  (saturated)
  );

endmodule

// ===== rtl/core/ccao_checker.sv =====
module ccao_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic signed [ccao_pkg::COORD_BITS-1:0] first_x,
  input logic signed [ccao_pkg::COORD_BITS-1:0] first_y,
  input logic signed [ccao_pkg::COORD_BITS-1:0] second_x,
  input logic signed [ccao_pkg::COORD_BITS-1:0] second_y,
  input logic signed [ccao_pkg::COORD_BITS-1:0] third_x,
  input logic signed [ccao_pkg::COORD_BITS-1:0] third_y,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [ccao_pkg::OUT_W-1:0]     circle_x,
  input logic signed [ccao_pkg::OUT_W-1:0]     circle_y,
  input logic                                  is_cw,
  input logic                                  degenerate,
  input logic                                  saturated
);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(circle_x) && $stable(circle_y)
      && $stable(is_cw) && $stable(degenerate) && $stable(saturated))
    else $error("result changed while stalled");

  // An empty output slot never blocks new requests.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request blocked with empty output");

  // Collinear points give a zero center and no other flags.
  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> circle_x == '0 && circle_y == '0 && !is_cw && !saturated)
    else $error("degenerate result not cleared");

  // A clipped result shows an extreme value in some coordinate.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      circle_x == ccao_pkg::OUT_MAX || circle_x == ccao_pkg::OUT_MIN ||
      circle_y == ccao_pkg::OUT_MAX || circle_y == ccao_pkg::OUT_MIN)
    else $error("saturated flag without clipped value");

endmodule

bind circumcenter_and_orientation ccao_checker u_ccao_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int LATENCY     = 62;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int CB          = ccao_pkg::COORD_BITS;
  localparam int OW          = ccao_pkg::OUT_W;

  typedef struct packed {
    logic signed [CB-1:0] x1, y1, x2, y2, x3, y3;
  } arc_req_t;

  typedef struct packed {
    logic signed [OW-1:0] cx;
    logic signed [OW-1:0] cy;
    logic                 cw;
    logic                 degen;
    logic                 sat;
  } center_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [CB-1:0] first_x, first_y, second_x, second_y, third_x, third_y;
  logic signed [OW-1:0] circle_x, circle_y;
  logic is_cw, degenerate, saturated;

  arc_req_t pending_reqs[$];
  center_t  expected_centers[$];
  int       send_idle_pct, recv_idle_pct;
  bit       hold_recv;
  bit       in_fire;
  int       hold_count;
  int       errors = 0;
  int       accepted_in = 0;
  int       accepted_out = 0;
  int       idle_cycles = 0;
  int       n_degen = 0;
  int       n_sat = 0;

  circumcenter_and_orientation u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .first_x(first_x), .first_y(first_y), .second_x(second_x),
    .second_y(second_y), .third_x(third_x), .third_y(third_y),
    .out_valid(out_valid), .out_ready(out_ready), .circle_x(circle_x),
    .circle_y(circle_y), .is_cw(is_cw), .degenerate(degenerate),
    .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Quotient num / (2a) scaled by 2^FRAC_BITS, truncated toward zero and clipped.
  function automatic logic signed [OW-1:0] scaled_quotient(
      logic signed [127:0] num, logic signed [127:0] a, ref bit sat);
    logic signed [127:0] q;
    logic signed [127:0] hi, lo;
    begin
      hi = (128'sd1 <<< (OW - 1)) - 128'sd1;
      lo = -(128'sd1 <<< (OW - 1));
      q = (num <<< ccao_pkg::FRAC_BITS) / (128'sd2 * a);
      if (q > hi) begin
        sat = 1'b1;
        q = hi;
      end else if (q < lo) begin
        sat = 1'b1;
        q = lo;
      end
      return q[OW-1:0];
    end
  endfunction

  // Circumcenter and orientation of one point triple.
  function automatic center_t predict_center(arc_req_t r);
    logic signed [127:0] dx2, dy2, dx3, dy3, s1, ds2, ds3, a, ny, nx;
    center_t c;
    bit sat;
    begin
      dx2 = 128'(r.x2) - 128'(r.x1);
      dy2 = 128'(r.y2) - 128'(r.y1);
      dx3 = 128'(r.x3) - 128'(r.x1);
      dy3 = 128'(r.y3) - 128'(r.y1);
      s1  = 128'(r.x1) * 128'(r.x1) + 128'(r.y1) * 128'(r.y1);
      ds2 = 128'(r.x2) * 128'(r.x2) + 128'(r.y2) * 128'(r.y2) - s1;
      ds3 = 128'(r.x3) * 128'(r.x3) + 128'(r.y3) * 128'(r.y3) - s1;
      a   = dx2 * dy3 - dx3 * dy2;
      c   = '0;
      sat = 1'b0;
      if (a == 0) begin
        c.degen = 1'b1;
      end else begin
        ny = ds2 * dy3 - ds3 * dy2;
        nx = ds3 * dx2 - ds2 * dx3;
        c.cx = scaled_quotient(ny, a, sat);
        c.cy = scaled_quotient(nx, a, sat);
        c.cw = (a > 0);
        c.sat = sat;
      end
      return c;
    end
  endfunction

  function automatic logic signed [CB-1:0] rand_coord(int mode);
    case (mode)
      0: return CB'($urandom);
      1: return CB'($urandom_range(0, 20) - 10);
      2: return $urandom_range(0, 1) ? CB'(32'h7fff - $urandom_range(0, 3))
                                      : CB'(32'h8000 + $urandom_range(0, 3));
      default: return CB'($urandom_range(0, 2000) - 1000);
    endcase
  endfunction

  task automatic add_req(int x1, int y1, int x2, int y2, int x3, int y3);
    arc_req_t r;
    begin
      r.x1 = CB'(x1); r.y1 = CB'(y1); r.x2 = CB'(x2);
      r.y2 = CB'(y2); r.x3 = CB'(x3); r.y3 = CB'(y3);
      pending_reqs.push_back(r);
    end
  endtask

  // Stimulus: directed corner cases, then random triples with a mix of ranges.
  initial begin
    arc_req_t r;
    int mode, k;
    add_req(0, 0, 1, 0, 0, 1);
    add_req(0, 0, 0, 1, 1, 0);
    add_req(0, 0, 0, 0, 0, 0);
    add_req(1, 1, 2, 2, 3, 3);
    add_req(-32768, -32768, 32767, 32767, 0, 0);
    add_req(-32768, -32768, 32767, -32768, -32768, 32767);
    add_req(32767, 32767, -32768, 32767, 32767, -32768);
    add_req(-32768, 32767, 32767, -32768, -32767, 32767);
    add_req(0, 0, 1, 0, -32768, 1);
    add_req(0, 0, 32767, 1, -32768, 0);
    add_req(-1, -1, 1, 1, 1, -1);
    add_req(10, 0, 0, 10, -10, 0);
    add_req(-10, 0, 0, 10, 10, 0);
    add_req(5, 5, 5, 5, 7, 9);
    add_req(32767, 0, 32767, 1, 32767, -32768);
    add_req(-1, -1, -1, -1, -1, -1);
    add_req(0, 1, 32767, 0, -32768, 0);
    for (k = 0; k < 850; k++) begin
      mode = $urandom_range(0, 3);
      r.x1 = rand_coord(mode); r.y1 = rand_coord(mode);
      r.x2 = rand_coord(mode); r.y2 = rand_coord(mode);
      if ($urandom_range(0, 9) == 0) begin
        // Collinear: third point on the line through the first two.
        r.x3 = CB'(r.x1 + 2 * (r.x2 - r.x1));
        r.y3 = CB'(r.y1 + 2 * (r.y2 - r.y1));
      end else begin
        r.x3 = rand_coord(mode); r.y3 = rand_coord(mode);
      end
      pending_reqs.push_back(r);
    end
  end

  // Reset, then three idling phases split over the request count.
  initial begin
    rst = 1'b1;
    send_idle_pct = 20;
    recv_idle_pct = 81;
    hold_recv = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    wait (accepted_in >= 300);
    @(negedge clk);
    send_idle_pct = 81;
    recv_idle_pct = 20;
    wait (accepted_in >= 550);
    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_recv = 1'b1;
    wait (pending_reqs.size() == 0 && expected_centers.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d point triples: %0d collinear, %0d clipped centers.",
             accepted_out, n_degen, n_sat);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Driver: presents the next request, holding it until accepted.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      {first_x, first_y, second_x, second_y, third_x, third_y} <= '0;
    end else if (!in_valid || in_fire) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        {first_x, first_y, second_x, second_y, third_x, third_y} <= pending_reqs[0];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver ready, with one long hold-off to fill the pipeline.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_count <= 0;
    end else if (hold_recv && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: records accepted requests and checks each result in order.
  always @(posedge clk) begin
    center_t got, exp_c;
    int n_err;
    n_err = 0;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        expected_centers.push_back(predict_center(pending_reqs.pop_front()));
        accepted_in <= accepted_in + 1;
      end
      if (out_valid && out_ready) begin
        got = {circle_x, circle_y, is_cw, degenerate, saturated};
        accepted_out <= accepted_out + 1;
        n_degen <= n_degen + int'(degenerate);
        n_sat <= n_sat + int'(saturated);
        if (expected_centers.size() == 0) begin
          n_err = n_err + 1;
          $display("%0t: unexpected result %h", $time, got);
        end else begin
          exp_c = expected_centers.pop_front();
          if (got.cx !== exp_c.cx) begin
            n_err = n_err + 1;
            $display("%0t: circle_x expected %0d actual %0d", $time, exp_c.cx, got.cx);
          end
          if (got.cy !== exp_c.cy) begin
            n_err = n_err + 1;
            $display("%0t: circle_y expected %0d actual %0d", $time, exp_c.cy, got.cy);
          end
          if (got.cw !== exp_c.cw) begin
            n_err = n_err + 1;
            $display("%0t: is_cw expected %b actual %b", $time, exp_c.cw, got.cw);
          end
          if (got.degen !== exp_c.degen) begin
            n_err = n_err + 1;
            $display("%0t: degenerate expected %b actual %b", $time,
                     exp_c.degen, got.degen);
          end
          if (got.sat !== exp_c.sat) begin
            n_err = n_err + 1;
            $display("%0t: saturated expected %b actual %b", $time, exp_c.sat, got.sat);
          end
        end
        errors <= errors + n_err;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
